// ----- rtl/tst_pkg.sv -----
// Package for the timeout slot table: sizes, request and status codes,
// the request, result and RAM control structs and the time conversion. No dependencies.
package tst_pkg;

	localparam int SLOTS    = 512;
	localparam int ADDR_W   = $clog2(SLOTS);
	localparam int SCAN_W   = ADDR_W + 1;
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int ID_EXT_W = (ADDR_W + 1 > 10) ? ADDR_W + 1 : 10;
	localparam int DATA_W   = 24 + 32 + 32 + 32;

	localparam logic [1:0] ACT_SET   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_POP   = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NONE    = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	localparam int SCALE_SHIFT = 11;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now;
		logic [31:0] handler;
		logic [31:0] argument;
		logic [31:0] duration;
		logic [9:0]  slot_id;
	} tst_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  entry_id;
		logic [23:0] entry_handler;
		logic [31:0] entry_argument;
		logic [31:0] entry_start;
		logic [31:0] entry_duration;
		logic [9:0]  active_count;
	} tst_result_t;

	typedef struct packed {
		logic              occ_we;
		logic              occ_wdata;
		logic              data_we;
		logic [ADDR_W-1:0] waddr;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} tst_ram_ctl_t;

	// Convert the raw down-counter into timer ticks.
	function automatic logic [31:0] current_time(input logic [31:0] raw);
		logic [31:0] t;
		t = {1'b0, ~raw[31:1]};
		return t + (t >> SCALE_SHIFT);
	endfunction

endpackage

// ----- rtl/timeout_slot_table_unit.sv -----
// Timeout slot table: invalid requests and clear by id zero finish from idle, clear
// by id first reads the slot's occupancy bit, and set and pop scan one slot per cycle
// through the single occupancy/entry RAM read port and the shared expiry compare.
// One request at a time; the next is taken once the result is in the output register.
// Reset: a clearing pass over all SLOTS slots zeroes the occupancy RAM; req_ready stays low.
// Depends on tst_pkg, tst_ram, tst_cmp, tst_ctrl.
module timeout_slot_table_unit import tst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  action,
	input  logic [31:0] raw_counter,
	input  logic [31:0] handler,
	input  logic [31:0] argument,
	input  logic [31:0] duration,
	input  logic [9:0]  slot_id,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [9:0]  entry_id,
	output logic [23:0] entry_handler,
	output logic [31:0] entry_argument,
	output logic [31:0] entry_start,
	output logic [31:0] entry_duration,
	output logic [9:0]  active_count
);

	tst_req_t          req;
	tst_ram_ctl_t      ram_ctl;
	logic [DATA_W-1:0] data_wdata;
	logic [DATA_W-1:0] data_rd;
	logic              occ_rd;
	logic              scan_pop;
	logic [31:0]       now;
	logic              hit;
	logic              res_valid;
	tst_result_t       res;
	logic              res_take;
	logic              rsp_valid_q;
	tst_result_t       rsp_q;

	// Convert the sampled down-counter to ticks on the way in.
	always_comb begin
		req.action   = action;
		req.now      = current_time(raw_counter);
		req.handler  = handler;
		req.argument = argument;
		req.duration = duration;
		req.slot_id  = slot_id;
	end

	// Occupancy bits: one per slot, zeroed by the clearing pass.
	tst_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_occ_ram (
		.clk   (clk),
		.we    (ram_ctl.occ_we),
		.waddr (ram_ctl.waddr),
		.wdata (ram_ctl.occ_wdata),
		.re    (ram_ctl.re),
		.raddr (ram_ctl.raddr),
		.rdata (occ_rd)
	);

	// Entry payload: handler, argument, start and duration; read together with the occupancy bit.
	tst_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_data_ram (
		.clk   (clk),
		.we    (ram_ctl.data_we),
		.waddr (ram_ctl.waddr),
		.wdata (data_wdata),
		.re    (ram_ctl.re),
		.raddr (ram_ctl.raddr),
		.rdata (data_rd)
	);

	// Shared test: free slot for set, start plus duration at most now for pop.
	tst_cmp u_cmp (
		.pop      (scan_pop),
		.occ      (occ_rd),
		.start    (data_rd[63:32]),
		.duration (data_rd[31:0]),
		.now      (now),
		.hit      (hit)
	);

	tst_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req        (req),
		.req_ready  (req_ready),
		.ram_ctl    (ram_ctl),
		.data_wdata (data_wdata),
		.occ_rd     (occ_rd),
		.data_rd    (data_rd),
		.scan_pop   (scan_pop),
		.now        (now),
		.hit        (hit),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take)
	);

	// Output register: load a finished result once the previous one has transferred.
	assign res_take = res_valid && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (res_take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the payload while the consumer stalls.
	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = rsp_q.status;
	assign entry_id       = rsp_q.entry_id;
	assign entry_handler  = rsp_q.entry_handler;
	assign entry_argument = rsp_q.entry_argument;
	assign entry_start    = rsp_q.entry_start;
	assign entry_duration = rsp_q.entry_duration;
	assign active_count   = rsp_q.active_count;

endmodule

// ----- rtl/tst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/tst_cmp.sv -----
// Shared slot test unit: free-slot test for set, expiry add and compare for pop.
// Depends on tst_pkg.
module tst_cmp import tst_pkg::*; (
	input  logic        pop,
	input  logic        occ,
	input  logic [31:0] start,
	input  logic [31:0] duration,
	input  logic [31:0] now,
	output logic        hit
);

	logic [31:0] deadline;

	assign deadline = start + duration;
	assign hit      = pop ? (occ && (deadline <= now)) : !occ;

endmodule

// ----- rtl/tst_ctrl.sv -----
// Sequencer of the timeout slot table: clearing pass, slot scan, clear by id.
// Depends on tst_pkg; drives the occupancy and entry RAMs and uses tst_cmp's hit.
module tst_ctrl import tst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  tst_req_t          req,
	output logic              req_ready,
	output tst_ram_ctl_t      ram_ctl,
	output logic [DATA_W-1:0] data_wdata,
	input  logic              occ_rd,
	input  logic [DATA_W-1:0] data_rd,
	output logic              scan_pop,
	output logic [31:0]       now,
	input  logic              hit,
	output logic              res_valid,
	output tst_result_t       res,
	input  logic              res_take
);

	typedef enum logic [2:0] {S_INIT, S_IDLE, S_SCAN, S_CLRCHK, S_FINISH} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] init_q;
	logic [SCAN_W-1:0] scan_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [1:0]        op_q;
	logic [31:0]       now_q;
	logic [23:0]       handler_q;
	logic [31:0]       argument_q;
	logic [31:0]       duration_q;
	logic [ADDR_W-1:0] slot_q;
	logic [1:0]        status_q;
	logic [9:0]        id_q;
	logic [23:0]       eh_q;
	logic [31:0]       ea_q;
	logic [31:0]       es_q;
	logic [31:0]       ed_q;
	logic [CNT_W-1:0]  count_q;

	logic [ID_EXT_W-1:0] slot_ext;
	logic                slot_ok;
	logic [ADDR_W-1:0]   slot_addr;
	logic                handler_ok;
	logic                accept;
	logic                issue;
	logic                found;
	logic                miss;

	assign slot_ext   = ID_EXT_W'(req.slot_id);
	assign slot_ok    = (slot_ext != '0) && (slot_ext <= ID_EXT_W'(SLOTS));
	assign slot_addr  = ADDR_W'(slot_ext - ID_EXT_W'(1));
	assign handler_ok = (req.handler != '0) && (req.handler[31:24] == 8'd0);

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign issue     = (state_q == S_SCAN) && (scan_q < SCAN_W'(SLOTS));
	assign found     = (state_q == S_SCAN) && vld_s1 && hit;
	assign miss      = (state_q == S_SCAN) && !vld_s1 && !issue;

	assign scan_pop = (op_q == ACT_POP);
	assign now      = now_q;

	always_comb begin
		ram_ctl.occ_we    = 1'b0;
		ram_ctl.occ_wdata = 1'b0;
		ram_ctl.data_we   = 1'b0;
		ram_ctl.waddr     = addr_s1;
		ram_ctl.re        = issue || (accept && (req.action == ACT_CLEAR) && slot_ok);
		ram_ctl.raddr     = (state_q == S_IDLE) ? slot_addr : scan_q[ADDR_W-1:0];
		if (state_q == S_INIT) begin
			ram_ctl.occ_we = 1'b1;
			ram_ctl.waddr  = init_q;
		end else if (found) begin
			ram_ctl.occ_we    = 1'b1;
			ram_ctl.occ_wdata = (op_q == ACT_SET);
			ram_ctl.data_we   = (op_q == ACT_SET);
		end else if ((state_q == S_CLRCHK) && occ_rd) begin
			ram_ctl.occ_we = 1'b1;
			ram_ctl.waddr  = slot_q;
		end
	end

	assign data_wdata = {handler_q, argument_q, now_q, duration_q};

	assign res_valid = (state_q == S_FINISH);
	always_comb begin
		res.status         = status_q;
		res.entry_id       = id_q;
		res.entry_handler  = eh_q;
		res.entry_argument = ea_q;
		res.entry_start    = es_q;
		res.entry_duration = ed_q;
		res.active_count   = 10'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			scan_q  <= '0;
			vld_s1  <= 1'b0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					init_q <= init_q + ADDR_W'(1);
					if (init_q == ADDR_W'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q       <= req.action;
						now_q      <= req.now;
						handler_q  <= req.handler[23:0];
						argument_q <= req.argument;
						duration_q <= req.duration;
						slot_q     <= slot_addr;
						id_q       <= '0;
						eh_q       <= '0;
						ea_q       <= '0;
						es_q       <= '0;
						ed_q       <= '0;
						scan_q     <= '0;
						vld_s1     <= 1'b0;
						status_q   <= ST_INVALID;
						state_q    <= S_FINISH;
						case (req.action)
							ACT_SET: begin
								if (handler_ok) begin
									state_q <= S_SCAN;
								end
							end
							ACT_CLEAR: begin
								if (req.slot_id == 10'd0) begin
									status_q <= ST_DONE;
								end else if (slot_ok) begin
									state_q <= S_CLRCHK;
								end
							end
							ACT_POP: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_SCAN: begin
					vld_s1  <= issue;
					addr_s1 <= scan_q[ADDR_W-1:0];
					if (issue) begin
						scan_q <= scan_q + SCAN_W'(1);
					end
					if (found) begin
						status_q <= ST_DONE;
						id_q     <= 10'(SCAN_W'(addr_s1) + SCAN_W'(1));
						state_q  <= S_FINISH;
						if (op_q == ACT_POP) begin
							count_q <= count_q - CNT_W'(1);
							eh_q    <= data_rd[DATA_W-1 -: 24];
							ea_q    <= data_rd[95:64];
							es_q    <= data_rd[63:32];
							ed_q    <= data_rd[31:0];
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end else if (miss) begin
						status_q <= (op_q == ACT_SET) ? ST_FULL : ST_NONE;
						state_q  <= S_FINISH;
					end
				end
				S_CLRCHK: begin
					if (occ_rd) begin
						count_q  <= count_q - CNT_W'(1);
						status_q <= ST_DONE;
						id_q     <= 10'(SCAN_W'(slot_q) + SCAN_W'(1));
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/tst_checker.sv -----
// Port-level checks for the timeout slot table, bound to the top level.
// Depends on tst_pkg and timeout_slot_table_unit.
module tst_checker import tst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  action,
	input logic [31:0] raw_counter,
	input logic [31:0] handler,
	input logic [31:0] argument,
	input logic [31:0] duration,
	input logic [9:0]  slot_id,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  status,
	input logic [9:0]  entry_id,
	input logic [23:0] entry_handler,
	input logic [31:0] entry_argument,
	input logic [31:0] entry_start,
	input logic [31:0] entry_duration,
	input logic [9:0]  active_count
);

	// One request in flight: a transfer drops ready on the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// Failed requests carry no id.
	a_fail_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_NONE || status == ST_FULL || status == ST_INVALID)
		|-> entry_id == 10'd0)
		else $error("failed request reports an id");

	// Entry fields are zero unless a request completed.
	a_fail_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_DONE |-> entry_handler == 24'd0 &&
		entry_argument == 32'd0 && entry_start == 32'd0 && entry_duration == 32'd0)
		else $error("entry fields set on a failed request");

	// A full table means every slot is counted.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> active_count == 10'(SLOTS))
		else $error("table full with free slots counted");

	// Stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_id))
		else $error("response changed while stalled");

endmodule

bind timeout_slot_table_unit tst_checker u_tst_checker (.*);
